// File: design/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, sizes and codes for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // Sizing
  localparam int MAX_TIMERS  = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W       = $clog2(MAX_TIMERS + 1);
  localparam logic [63:0] COUNT_MAX64 =
    (COUNT_WIDTH == 64) ? '1 : ((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [3:0]             slot_t;

  // Input kind codes
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ATTACH = 1'b1;

  // Result kind codes
  localparam logic [1:0] RK_FIRED   = 2'd0;
  localparam logic [1:0] RK_ACCEPT  = 2'd1;
  localparam logic [1:0] RK_REFUSED = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] period;
    logic [7:0]  handler_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    slot_t      slot;
    logic [7:0] fired_handler;
    logic       last;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ATTACH,
    ST_WALK,
    ST_DRAIN
  } ptb_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input transaction, set up walk index
    logic attach;  // perform attach and emit its result
    logic step;    // process one slot of the walk
    logic drain;   // emit held firing as the final result
  } ptb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic idx_zero;
    logic fire;
    logic pend_valid;
    logic out_free;
  } ptb_stat_t;

  // Clamp a 32-bit period to the counter range
  function automatic count_t sat_period(input logic [31:0] p);
    if (64'(p) > COUNT_MAX64) begin
      return '1;
    end
    return COUNT_WIDTH'(p);
  endfunction

endpackage

// File: design/periodic_timer_bank_core.sv
`timescale 1ns / 1ps
// Flow: an attach result is registered from the ATTACH state once the
//   output register is free. An attach passes through IDLE and ATTACH; a tick
//   is accepted in IDLE, walks the filled slots one step per slot and ends in
//   DRAIN, flushing any held firing; a tick on an empty bank is only accepted.
//   Stalls add.
// Reset: synchronous active-low rst_n empties the bank and drops any result.
// ----------------------------------------------------------------------------
// periodic_timer_bank_core
// Bank of periodic timers: attach requests fill slots, ticks walk all filled
// slots from newest to oldest and report each firing.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ptb_pkg::out_item_t out_data
);
  import ptb_pkg::*;

  ptb_cmd_t  cmd;
  ptb_stat_t st;

  // Sequencer
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables and result path
  ptb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// File: design/ptb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: accepts one transaction at a time and steps the datapath
// through an attach or a newest-to-oldest walk of the filled slots.
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  input  ptb_pkg::ptb_stat_t st,
  output ptb_pkg::ptb_cmd_t  cmd
);
  import ptb_pkg::*;

  ptb_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_ATTACH) begin
            state_nxt = ST_ATTACH;
          end else if (!st.empty) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_ATTACH: begin
        if (st.out_free) begin
          cmd.attach = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_WALK: begin
        // Hold the walk only when a new firing must displace a held one and the output register is not free
        if (!st.fire || !st.pend_valid || st.out_free) begin
          cmd.step = 1'b1;
          if (st.idx_zero) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.drain = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/ptb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_dp
// Timer tables, walk index, one-deep firing hold and the output register.
// ----------------------------------------------------------------------------
module ptb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ptb_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output ptb_pkg::out_item_t out_data,
  input  ptb_pkg::ptb_cmd_t  cmd,
  output ptb_pkg::ptb_stat_t st
);
  import ptb_pkg::*;

  count_t     period_tab [MAX_TIMERS];
  count_t     rem_tab    [MAX_TIMERS];
  logic [7:0] hnd_tab    [MAX_TIMERS];

  in_item_t   item_r;
  cnt_t       count_r;
  idx_t       idx_r;
  logic       pend_valid_r;
  out_item_t  pend_r;
  logic       out_valid_r;
  out_item_t  out_r;

  cnt_t       cnt_m1;
  idx_t       wr_idx;
  logic       full;
  count_t     cur_period;
  count_t     rem_dec;
  logic       fire;
  logic       out_free;
  count_t     new_period;

  // Decode current slot of the walk
  assign cnt_m1     = count_r - CNT_W'(1);
  assign wr_idx     = count_r[IDX_W-1:0];
  assign full       = (count_r == CNT_W'(MAX_TIMERS));
  assign cur_period = period_tab[idx_r];
  assign rem_dec    = rem_tab[idx_r] - COUNT_WIDTH'(1);
  assign fire       = (cur_period == '0) || (rem_dec == '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign new_period = sat_period(item_r.period);

  assign st.empty      = (count_r == '0);
  assign st.idx_zero   = (idx_r == '0);
  assign st.fire       = fire;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Capture transaction and set up the walk from the newest slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      idx_r  <= cnt_m1[IDX_W-1:0];
    end else if (cmd.step && !st.idx_zero) begin
      idx_r  <= idx_r - IDX_W'(1);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.attach && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Table writes: attach fills the next slot, a walk step updates its count
  always_ff @(posedge clk) begin
    if (cmd.attach && !full) begin
      period_tab[wr_idx] <= new_period;
      rem_tab[wr_idx]    <= new_period;
      hnd_tab[wr_idx]    <= item_r.handler_id;
    end else if (cmd.step && (cur_period != '0)) begin
      rem_tab[idx_r] <= (rem_dec == '0) ? cur_period : rem_dec;
    end
  end

  // Hold the latest firing until the next one shows it was not the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.step && fire) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.drain) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && fire) begin
      pend_r.result_kind   <= RK_FIRED;
      pend_r.slot          <= slot_t'(idx_r);
      pend_r.fired_handler <= hnd_tab[idx_r];
      pend_r.last          <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.attach || cmd.drain || (cmd.step && fire && pend_valid_r)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.attach) begin
      out_r.result_kind   <= full ? RK_REFUSED : RK_ACCEPT;
      out_r.slot          <= full ? slot_t'(0) : slot_t'(wr_idx);
      out_r.fired_handler <= item_r.handler_id;
      out_r.last          <= 1'b1;
    end else if (cmd.drain) begin
      out_r.result_kind   <= pend_r.result_kind;
      out_r.slot          <= pend_r.slot;
      out_r.fired_handler <= pend_r.fired_handler;
      out_r.last          <= 1'b1;
    end else if (cmd.step && fire && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

endmodule

// File: design/ptb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks on the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ptb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ptb_pkg::out_item_t out_data
);
  import ptb_pkg::*;

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Busy after accepting an attach
  a_attach_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind == KIND_ATTACH) |=> in_stall)
    else $error("attach transaction not held busy");

  // Attach answers are single results, always marked last
  a_attach_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != RK_FIRED) |-> out_data.last)
    else $error("attach result not marked last");

  // Only defined result kinds
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == RK_FIRED) ||
                  (out_data.result_kind == RK_ACCEPT) ||
                  (out_data.result_kind == RK_REFUSED))
    else $error("undefined result kind");

endmodule

bind periodic_timer_bank_core ptb_checker u_ptb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/periodic_timer_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_checker
// Watches both channels of the timer bank, keeps its own copy of the slot
// tables, predicts every result an accepted transaction should produce and
// compares the results that leave the block against them in order.
// ----------------------------------------------------------------------------
module periodic_timer_bank_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ptb_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ptb_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 results_owed
);
  import ptb_pkg::*;

  // Shadow copy of the bank
  int         armed_timers;
  count_t     reload_of  [MAX_TIMERS];
  count_t     countdown  [MAX_TIMERS];
  logic [7:0] handler_of [MAX_TIMERS];

  // Results still to come, oldest first
  out_item_t  owed_q[$];
  int         fail_tally = 0;

  assign fail_count   = fail_tally;
  assign results_owed = owed_q.size();

  // Clip a requested period to what the counter can hold
  function automatic count_t fit_period(input logic [31:0] req);
    logic [63:0] wide;
    wide = {32'd0, req};
    if (wide > COUNT_MAX64) begin
      wide = COUNT_MAX64;
    end
    return count_t'(wide);
  endfunction

  // Apply one input transaction to the shadow bank and queue its results
  function automatic void advance_bank(input in_item_t item);
    out_item_t res;
    out_item_t held;
    logic      have_held;
    logic      fire;
    int        s;
    if (item.kind == KIND_ATTACH) begin
      res.fired_handler = item.handler_id;
      res.last          = 1'b1;
      if (armed_timers >= MAX_TIMERS) begin
        res.result_kind = RK_REFUSED;
        res.slot        = '0;
      end else begin
        reload_of[armed_timers]  = fit_period(item.period);
        countdown[armed_timers]  = fit_period(item.period);
        handler_of[armed_timers] = item.handler_id;
        res.result_kind          = RK_ACCEPT;
        res.slot                 = slot_t'(armed_timers);
        armed_timers++;
      end
      owed_q.push_back(res);
      return;
    end
    // Walk newest to oldest; hold back each firing until the next one shows
    // whether it is the final result of this tick
    have_held = 1'b0;
    held      = '0;
    for (s = armed_timers - 1; s >= 0; s--) begin
      fire = 1'b0;
      if (reload_of[s] == '0) begin
        fire = 1'b1;
      end else begin
        countdown[s] = countdown[s] - 1'b1;
        if (countdown[s] == '0) begin
          countdown[s] = reload_of[s];
          fire         = 1'b1;
        end
      end
      if (fire) begin
        if (have_held) begin
          owed_q.push_back(held);
        end
        held.result_kind   = RK_FIRED;
        held.slot          = slot_t'(s);
        held.fired_handler = handler_of[s];
        held.last          = 1'b0;
        have_held          = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      owed_q.push_back(held);
    end
  endfunction

  // Compare leaving transactions first, then predict for the entering one
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      armed_timers = 0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10) begin
            $display("%0t: unexpected result kind %0d slot %0d handler %0d last %0d",
                     $realtime, out_data.result_kind, out_data.slot,
                     out_data.fired_handler, out_data.last);
          end
        end else begin
          want = owed_q.pop_front();
          if (out_data.result_kind !== want.result_kind || out_data.slot !== want.slot ||
              out_data.fired_handler !== want.fired_handler ||
              out_data.last !== want.last) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("%0t: result mismatch, expected kind %0d slot %0d handler %0d last %0d,",
                       $realtime, want.result_kind, want.slot, want.fired_handler,
                       want.last);
              $display("    got kind %0d slot %0d handler %0d last %0d",
                       out_data.result_kind, out_data.slot, out_data.fired_handler,
                       out_data.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_bank(in_data);
      end
    end
  end

endmodule

// File: test/periodic_timer_bank_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_core_tb
// Drives attach and tick transactions into the timer bank: a directed run
// that fills the table, fires every kind of period and hits the full-table
// refusal, then random traffic under changing sender gaps and receiver stalls.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core_tb;
  import ptb_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int        fail_count;
  int        results_owed;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  always #5 clk = ~clk;

  periodic_timer_bank_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  periodic_timer_bank_checker bank_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic in_item_t attach_item(input logic [31:0] period, input logic [7:0] hid);
    in_item_t it;
    it.kind       = KIND_ATTACH;
    it.period     = period;
    it.handler_id = hid;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it.kind       = KIND_TICK;
    it.period     = $urandom;
    it.handler_id = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Mostly ticks; attaches carry short periods or full-range ones
  function automatic in_item_t random_item();
    in_item_t it;
    it.kind       = ($urandom_range(0, 99) < 30) ? KIND_ATTACH : KIND_TICK;
    it.period     = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
    it.handler_id = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one transaction and hold it until accepted; enter and leave at a falling edge
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  initial begin
    int k;
    int phase;
    int drain;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tick, every-tick, unit, longest and top-bit periods
    send_item(tick_item());
    send_item(attach_item(32'd0, 8'hFF));
    send_item(tick_item());
    send_item(attach_item(32'd1, 8'h00));
    send_item(attach_item(32'hFFFF_FFFF, 8'hA5));
    send_item(attach_item(32'd2, 8'h5A));
    send_item(tick_item());
    send_item(tick_item());
    send_item(attach_item(32'h8000_0000, 8'h01));
    // Fill the remaining slots with short periods
    for (k = 5; k < MAX_TIMERS; k++) begin
      send_item(attach_item(32'($urandom_range(0, 4)), 8'($urandom_range(0, 255))));
    end
    // Full table: refusals and ticks over every slot
    send_item(attach_item(32'hFFFF_FFFF, 8'h7E));
    send_item(tick_item());
    send_item(attach_item(32'd0, 8'h81));
    send_item(tick_item());

    // Random traffic under four idling profiles
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      for (k = 0; k < 62; k++) begin
        send_item(random_item());
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow one full walk for strays
    drain = 0;
    while (results_owed != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("periodic_timer_bank_core_tb OK");
    end else begin
      $display("periodic_timer_bank_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("periodic_timer_bank_core_tb NOT OK");
    $finish;
  end

endmodule
